### src/agcp_pkg.sv
// agcp_pkg: shared codes, character constants and digit helpers of the
// ascii gain command parser; no dependencies
`default_nettype none

package agcp_pkg;

  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharEnd   = 8'h21;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharI     = 8'h49;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharTwo   = 8'h32;

  localparam int unsigned WinDepth = 6;
  localparam int unsigned CntW     = 3;   // value length saturates at 7, only 4..6 matter

  localparam logic RegMotorSelect = 1'b0; // paddr[2] of the motor select register

  typedef enum logic [2:0] {
    KeyNone = 3'd0,
    KeyP1   = 3'd1,
    KeyI1   = 3'd2,
    KeyD1   = 3'd3,
    KeyP2   = 3'd4,
    KeyI2   = 3'd5,
    KeyD2   = 3'd6
  } key_code_e;

  typedef enum logic [1:0] {
    GainNone  = 2'd0,
    GainProp  = 2'd1,
    GainInt   = 2'd2,
    GainDeriv = 2'd3
  } gain_sel_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharZero + 8'd9);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CharZero;
    return d[3:0];
  endfunction

  function automatic key_code_e key_decode(input logic [7:0] a, input logic [7:0] b);
    key_code_e k;
    k = KeyNone;
    if (b == CharOne) begin
      if (a == CharP) k = KeyP1;
      else if (a == CharI) k = KeyI1;
      else if (a == CharD) k = KeyD1;
    end else if (b == CharTwo) begin
      if (a == CharP) k = KeyP2;
      else if (a == CharI) k = KeyI2;
      else if (a == CharD) k = KeyD2;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### src/agcp_byte_if.sv
// agcp_byte_if: valid/ready channel carrying one received character
// no dependencies
`default_nettype none

interface agcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/agcp_result_if.sv
// agcp_result_if: valid/ready channel carrying one parsed command result
// no dependencies
`default_nettype none

interface agcp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         key_code;
  logic signed [17:0] value_hundredths;
  logic [1:0]         gain_written;
  logic [7:0]         proportional_gain;
  logic [7:0]         integral_gain;
  logic [7:0]         derivative_gain;
  logic               frame_error;

  modport source (output valid, output key_code, output value_hundredths,
                  output gain_written, output proportional_gain,
                  output integral_gain, output derivative_gain,
                  output frame_error, input ready);
  modport sink   (input valid, input key_code, input value_hundredths,
                  input gain_written, input proportional_gain,
                  input integral_gain, input derivative_gain,
                  input frame_error, output ready);
endinterface

`default_nettype wire

### src/ascii_gain_command_parser_unit.sv
// ascii_gain_command_parser_unit: top level, parses key=value! commands
// and keeps the speed loop gains; uses agcp_pkg, agcp_byte_if, agcp_result_if
//
//   channel  | dir | word                              | handshake
//   ---------+-----+-----------------------------------+-----------
//   rx_i     | in  | one received character            | valid/ready
//   res_o    | out | key, value, gains, error per '!'  | valid/ready
//   apb      | in  | motor select register (addr 0)    | psel/penable
//
// one character a cycle while no '!' stalls: a byte is held in the input register, then
// the frame state and, on '!', the result register are updated from it
// an accepted '!' passes the input register, then the result register, to its word
// reset clears frame state and gains, motor select comes up as 1
// only a '!' waits on a full result register; other bytes pass regardless
`default_nettype none

module ascii_gain_command_parser_unit import agcp_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  agcp_byte_if.sink        rx_i,
  agcp_result_if.source    res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned PosW = $clog2(MAX_FRAME + 1);

  // configuration
  logic motor_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMotorSelect) ? {31'd0, motor_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == RegMotorSelect)) begin
      motor_q <= pwdata[0];
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_is_end;
  logic       in_go;

  assign in_is_end = (in_byte_q == CharEnd);
  assign in_go     = in_valid_q && (!in_is_end || !res_o.valid || res_o.ready);
  assign rx_i.ready = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // frame state
  logic [7:0]      key_q [2];
  logic [PosW-1:0] pos_q;
  logic            seen_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]      win_q [WinDepth];
  logic            over_q;
  logic [7:0]      gain_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '{default: '0};
      pos_q  <= '0;
      seen_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      win_q  <= '{default: '0};
      over_q <= 1'b0;
    end else if (in_go) begin
      if (in_is_end) begin
        key_q  <= '{default: '0};
        pos_q  <= '0;
        seen_q <= 1'b0;
        neg_q  <= 1'b0;
        cnt_q  <= '0;
        win_q  <= '{default: '0};
        over_q <= 1'b0;
      end else if (pos_q >= PosW'(MAX_FRAME)) begin
        over_q <= 1'b1;
      end else begin
        if (pos_q < PosW'(2)) begin
          key_q[pos_q[0]] <= in_byte_q;
        end
        pos_q <= pos_q + PosW'(1);
        if (in_byte_q == CharEq) begin
          seen_q <= 1'b1;
          neg_q  <= 1'b0;
          cnt_q  <= '0;
          win_q  <= '{default: '0};
        end else if (seen_q) begin
          if (in_byte_q == CharMinus && cnt_q == '0 && !neg_q) begin
            neg_q <= 1'b1;
          end else begin
            for (int i = 0; i < WinDepth - 1; i++) begin
              win_q[i] <= win_q[i+1];
            end
            win_q[WinDepth-1] <= in_byte_q;
            if (cnt_q != '1) cnt_q <= cnt_q + CntW'(1);
          end
        end
      end
    end
  end

  // value decode: win_q[5] newest, [4] tenths, [3] point, [2..0] integer digits
  logic               len_ok;
  logic               dig_err;
  logic               err;
  logic [3:0]         e0, e1;
  logic [9:0]         ip;
  logic [16:0]        mag;
  logic               val_ok;
  logic [9:0]         ip_used;
  logic [16:0]        mag_used;
  logic signed [17:0] val;
  key_code_e          key;
  logic               wr_en;
  logic [7:0]         g_new;
  gain_sel_e          written;

  always_comb begin
    len_ok  = (cnt_q == CntW'(4)) || (cnt_q == CntW'(5)) || (cnt_q == CntW'(6));
    dig_err = !is_digit(win_q[5]) || !is_digit(win_q[4]) || !is_digit(win_q[2])
              || ((cnt_q != CntW'(4)) && !is_digit(win_q[1]))
              || ((cnt_q == CntW'(6)) && !is_digit(win_q[0]));
    err     = over_q || !seen_q || (len_ok && dig_err);
    e0      = (cnt_q == CntW'(6)) ? digit_val(win_q[0]) : 4'd0;
    e1      = (cnt_q != CntW'(4)) ? digit_val(win_q[1]) : 4'd0;
    ip      = 10'(e0) * 10'd100 + 10'(e1) * 10'd10 + 10'(digit_val(win_q[2]));
    mag     = 17'(ip) * 17'd100 + 17'(digit_val(win_q[4])) * 17'd10
              + 17'(digit_val(win_q[5]));
    val_ok   = !err && len_ok;
    ip_used  = val_ok ? ip : 10'd0;
    mag_used = val_ok ? mag : 17'd0;
    val      = neg_q ? -$signed({1'b0, mag_used}) : $signed({1'b0, mag_used});
    key      = key_decode(key_q[0], key_q[1]);
    wr_en    = !err && motor_q
               && (key == KeyP1 || key == KeyI1 || key == KeyD1);
    // negatives clamp to 0, integer parts above 255 to 255
    if (neg_q) g_new = 8'd0;
    else if (ip_used > 10'd255) g_new = 8'd255;
    else g_new = ip_used[7:0];
    case (key)
      KeyP1:   written = wr_en ? GainProp : GainNone;
      KeyI1:   written = wr_en ? GainInt : GainNone;
      KeyD1:   written = wr_en ? GainDeriv : GainNone;
      default: written = GainNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '{default: '0};
    end else if (in_go && in_is_end && wr_en) begin
      case (written)
        GainProp:  gain_q[0] <= g_new;
        GainInt:   gain_q[1] <= g_new;
        GainDeriv: gain_q[2] <= g_new;
        default:   ;
      endcase
    end
  end

  // result register; gains only change when a result loads, so they drive
  // the port straight from the gain store
  logic               res_valid_q;
  logic [2:0]         res_key_q;
  logic signed [17:0] res_val_q;
  logic [1:0]         res_written_q;
  logic               res_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_go && in_is_end) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_is_end) begin
      res_key_q     <= key;
      res_val_q     <= val;
      res_written_q <= written;
      res_err_q     <= err;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.key_code          = res_key_q;
  assign res_o.value_hundredths  = res_val_q;
  assign res_o.gain_written      = res_written_q;
  assign res_o.proportional_gain = gain_q[0];
  assign res_o.integral_gain     = gain_q[1];
  assign res_o.derivative_gain   = gain_q[2];
  assign res_o.frame_error       = res_err_q;

endmodule

`default_nettype wire
